// ===== rtl/core/ldfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldfs_pkg
// Shared types and constants of the two-wire LED display frame sender.
// ----------------------------------------------------------------------------
package ldfs_pkg;

  localparam int FRAME_BYTES_DEF = 6;
  localparam int MAX_BYTES       = 6;
  localparam int ADDR_W          = 4;
  localparam int DATA_W          = 32;

  localparam logic [7:0] DCMD_RST = 8'h40;
  localparam logic [7:0] ADDR_RST = 8'hC0;
  localparam logic [7:0] DISP_RST = 8'h88 | 8'h07;

  localparam logic [1:0] REG_DCMD = 2'd0;
  localparam logic [1:0] REG_ADDR = 2'd1;
  localparam logic [1:0] REG_DISP = 2'd2;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_DCMD = 4'b0010,
    PH_SEND = 4'b0100,
    PH_DISP = 4'b1000
  } phase_t;

  typedef enum logic [4:0] {
    BS_START = 5'b00001,
    BS_ADDR  = 5'b00010,
    BS_ACK   = 5'b00100,
    BS_DATA  = 5'b01000,
    BS_STOP  = 5'b10000
  } bus_step_t;

  typedef struct packed {
    logic [7:0] data_command;
    logic [7:0] address_byte;
    logic [7:0] display_command;
  } cfg_t;

  typedef struct packed {
    logic                       op;
    logic                       sda_in;
    logic [MAX_BYTES-1:0][7:0]  bytes;
  } req_t;

  typedef struct packed {
    logic scl;
    logic sda_level;
    logic sda_drive;
    logic busy_res;
    logic accepted;
    logic frame_done;
    logic ack_missing;
  } res_t;

endpackage

// ===== rtl/core/ldfs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldfs_req_if / ldfs_rsp_if
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
interface ldfs_req_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic       sda_in;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic [7:0] byte4;
  logic [7:0] byte5;

  modport source (output valid, op, sda_in, byte0, byte1, byte2, byte3, byte4, byte5,
                  input ready);
  modport sink (input valid, op, sda_in, byte0, byte1, byte2, byte3, byte4, byte5,
                output ready);
endinterface

interface ldfs_rsp_if;
  logic valid;
  logic ready;
  logic scl;
  logic sda_level;
  logic sda_drive;
  logic busy_res;
  logic accepted;
  logic frame_done;
  logic ack_missing;

  modport source (output valid, scl, sda_level, sda_drive, busy_res, accepted,
                  frame_done, ack_missing, input ready);
  modport sink (input valid, scl, sda_level, sda_drive, busy_res, accepted,
                frame_done, ack_missing, output ready);
endinterface

// ===== rtl/core/led_display_two_wire_frame_sender.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_display_two_wire_frame_sender
// Two-wire LED display master, one bus step per tick item.
// ----------------------------------------------------------------------------
// Each request item is either a tick, which moves the SCL/SDA sequencer on by
// one step, or a frame push, which is taken only while idle and starts the
// data command, address-plus-data and display command transactions. Every
// item gives exactly one result item with the line levels after the step and
// status flags. Items may be presented every cycle: one item a cycle is taken
// while the result side does not stall, and its result passes through the input
// register, then the sequencer update into the result register. Stalls on the
// result side back up through the input register.
module led_display_two_wire_frame_sender #(
  parameter int FRAME_BYTES = ldfs_pkg::FRAME_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ldfs_pkg::ADDR_W-1:0]   paddr,
  input  logic [ldfs_pkg::DATA_W-1:0]   pwdata,
  output logic [ldfs_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  ldfs_req_if.sink                      req,
  ldfs_rsp_if.source                    rsp
);
  import ldfs_pkg::*;

  cfg_t cfg;
  req_t in_item;
  logic in_vld;
  res_t step_res;
  res_t out_res;
  logic out_vld;
  logic adv;
  logic fire;

  assign adv       = !out_vld || rsp.ready;
  assign fire      = in_vld && adv;
  assign req.ready = !in_vld || adv;

  ldfs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (req.ready) begin
      in_vld <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item.op     <= req.op;
      in_item.sda_in <= req.sda_in;
      in_item.bytes  <= {req.byte5, req.byte4, req.byte3, req.byte2, req.byte1, req.byte0};
    end
  end

  ldfs_seq #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_seq (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (in_item),
    .cfg  (cfg),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (fire) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= step_res;
    end
  end

  assign rsp.valid       = out_vld;
  assign rsp.scl         = out_res.scl;
  assign rsp.sda_level   = out_res.sda_level;
  assign rsp.sda_drive   = out_res.sda_drive;
  assign rsp.busy_res    = out_res.busy_res;
  assign rsp.accepted    = out_res.accepted;
  assign rsp.frame_done  = out_res.frame_done;
  assign rsp.ack_missing = out_res.ack_missing;

endmodule

// ===== rtl/core/ldfs_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldfs_cfg
// APB register file: data command, address byte, display command.
// ----------------------------------------------------------------------------
module ldfs_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ldfs_pkg::ADDR_W-1:0]   paddr,
  input  logic [ldfs_pkg::DATA_W-1:0]   pwdata,
  output logic [ldfs_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output ldfs_pkg::cfg_t                cfg
);
  import ldfs_pkg::*;

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.data_command    <= DCMD_RST;
      cfg.address_byte    <= ADDR_RST;
      cfg.display_command <= DISP_RST;
    end else if (wr) begin
      case (idx)
        REG_DCMD: cfg.data_command    <= pwdata[7:0];
        REG_ADDR: cfg.address_byte    <= pwdata[7:0];
        REG_DISP: cfg.display_command <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DCMD: prdata = {24'd0, cfg.data_command};
      REG_ADDR: prdata = {24'd0, cfg.address_byte};
      REG_DISP: prdata = {24'd0, cfg.display_command};
      default:  prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/ldfs_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldfs_seq
// Bus sequencer: line state, frame store and one-step update per item.
// ----------------------------------------------------------------------------
module ldfs_seq #(
  parameter int FRAME_BYTES = ldfs_pkg::FRAME_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  ldfs_pkg::req_t item,
  input  ldfs_pkg::cfg_t cfg,
  output ldfs_pkg::res_t res
);
  import ldfs_pkg::*;

  localparam int         IDX_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam logic [2:0] LAST  = 3'(FRAME_BYTES);

  phase_t    phase, phase_next;
  bus_step_t bstep, bstep_next;
  logic [1:0] sub, sub_next;
  logic [3:0] bitcnt, bitcnt_next;
  logic [2:0] bidx, bidx_next;
  logic       scl, scl_next;
  logic       lvl, lvl_next;
  logic       drv, drv_next;

  logic [7:0] store [FRAME_BYTES];

  logic       store_we;
  logic       do_send;
  logic       count_byte;
  logic [7:0] tx;
  logic       acc, done, miss;

  always_comb begin
    phase_next  = phase;
    bstep_next  = bstep;
    sub_next    = sub;
    bitcnt_next = bitcnt;
    bidx_next   = bidx;
    scl_next    = scl;
    lvl_next    = lvl;
    drv_next    = drv;
    store_we    = 1'b0;
    do_send     = 1'b0;
    count_byte  = 1'b0;
    tx          = cfg.address_byte;
    acc         = 1'b0;
    done        = 1'b0;
    miss        = 1'b0;

    if (item.op) begin
      if (phase == PH_IDLE) begin
        store_we   = 1'b1;
        phase_next = PH_DCMD;
        acc        = 1'b1;
      end
    end else if (phase != PH_IDLE) begin
      case (bstep)
        BS_START: begin
          if (phase == PH_SEND) bidx_next = 3'd0;
          case (sub)
            2'd0: begin
              drv_next = 1'b1;
              lvl_next = 1'b1;
              scl_next = 1'b1;
              sub_next = 2'd1;
            end
            2'd1: begin
              lvl_next = 1'b0;
              sub_next = 2'd2;
            end
            2'd2: sub_next = 2'd3;
            default: begin
              scl_next   = 1'b0;
              sub_next   = 2'd0;
              bstep_next = (phase == PH_SEND) ? BS_ADDR : BS_DATA;
            end
          endcase
        end
        BS_ADDR: begin
          if (phase == PH_SEND) begin
            do_send = 1'b1;
          end else begin
            bstep_next = BS_START;
            sub_next   = 2'd0;
            phase_next = PH_IDLE;
          end
        end
        BS_ACK: begin
          case (sub)
            2'd0: begin
              drv_next = 1'b0;
              sub_next = 2'd1;
            end
            2'd1: begin
              scl_next = 1'b1;
              sub_next = 2'd2;
            end
            2'd2: begin
              miss       = item.sda_in;
              scl_next   = 1'b0;
              sub_next   = 2'd0;
              bstep_next = (phase == PH_SEND) ? BS_DATA : BS_STOP;
            end
            default: sub_next = 2'd0;
          endcase
        end
        BS_DATA: begin
          if (phase == PH_SEND) begin
            if (bidx >= LAST) begin
              bidx_next  = 3'd0;
              bstep_next = BS_STOP;
            end else begin
              do_send    = 1'b1;
              count_byte = 1'b1;
              tx         = store[bidx[IDX_W-1:0]];
            end
          end else begin
            do_send = 1'b1;
            tx      = (phase == PH_DCMD) ? cfg.data_command : cfg.display_command;
          end
        end
        BS_STOP: begin
          case (sub)
            2'd0: begin
              drv_next = 1'b1;
              scl_next = 1'b0;
              lvl_next = 1'b0;
              sub_next = 2'd1;
            end
            2'd1: begin
              scl_next   = 1'b1;
              lvl_next   = 1'b1;
              sub_next   = 2'd0;
              bstep_next = BS_START;
              if (phase == PH_DCMD) begin
                phase_next = PH_SEND;
              end else if (phase == PH_SEND) begin
                phase_next = PH_DISP;
              end else begin
                phase_next = PH_IDLE;
                done       = 1'b1;
              end
            end
            default: sub_next = 2'd0;
          endcase
        end
        default: begin
          bstep_next = BS_START;
          sub_next   = 2'd0;
          phase_next = PH_IDLE;
        end
      endcase

      // shared byte shifter, LSB first, three ticks a bit
      if (do_send) begin
        case (sub)
          2'd0: begin
            bitcnt_next = 4'd0;
            drv_next    = 1'b1;
            scl_next    = 1'b0;
            sub_next    = 2'd1;
          end
          2'd1: begin
            lvl_next    = tx[bitcnt[2:0]];
            bitcnt_next = bitcnt + 4'd1;
            sub_next    = 2'd2;
          end
          2'd2: begin
            scl_next = 1'b1;
            sub_next = 2'd3;
          end
          default: begin
            scl_next = 1'b0;
            sub_next = 2'd1;
            if (bitcnt >= BITS_PER_BYTE) begin
              sub_next   = 2'd0;
              bstep_next = BS_ACK;
              if (count_byte) bidx_next = bidx + 3'd1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      bstep  <= BS_START;
      sub    <= 2'd0;
      bitcnt <= 4'd0;
      bidx   <= 3'd0;
      scl    <= 1'b1;
      lvl    <= 1'b1;
      drv    <= 1'b1;
    end else if (fire) begin
      phase  <= phase_next;
      bstep  <= bstep_next;
      sub    <= sub_next;
      bitcnt <= bitcnt_next;
      bidx   <= bidx_next;
      scl    <= scl_next;
      lvl    <= lvl_next;
      drv    <= drv_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && store_we) begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
        store[i] <= item.bytes[i];
      end
    end
  end

  assign res.scl         = scl_next;
  assign res.sda_level   = lvl_next;
  assign res.sda_drive   = drv_next;
  assign res.busy_res    = (phase_next != PH_IDLE);
  assign res.accepted    = acc;
  assign res.frame_done  = done;
  assign res.ack_missing = miss;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    fire && done |=> phase == PH_IDLE)
    else $error("frame done but sequencer not idle");

  a_ack_released: assert property (@(posedge clk) disable iff (rst)
    fire && miss |-> !drv)
    else $error("acknowledge sampled while SDA driven");

  a_sda_scl_high: assert property (@(posedge clk) disable iff (rst)
    fire && scl && scl_next && drv && (lvl_next != lvl) |->
      (bstep == BS_START || bstep == BS_STOP))
    else $error("SDA moved under high SCL outside start or stop");

  a_idle_parked: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> (bstep == BS_START && sub == 2'd0))
    else $error("idle with bus step not parked");

endmodule

// ===== dv/led_display_two_wire_frame_sender_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_display_two_wire_frame_sender_tb
// Self-checking bench for the two-wire LED display frame sender. Request items
// (ticks and frame pushes) are driven from a queue; a line-level model of the
// start/byte/ack/stop sequencer predicts every result item, which is checked
// field by field. Register settings change between frames over the APB port.
// ----------------------------------------------------------------------------
module led_display_two_wire_frame_sender_tb;
  import ldfs_pkg::*;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_PUSH = 1'b1;
  localparam int   LONG_HOLD = 64;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  ldfs_req_if req_ch ();
  ldfs_rsp_if rsp_ch ();

  led_display_two_wire_frame_sender dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  // sequencer model state
  phase_t     seq_ph;
  bus_step_t  bus_st;
  logic [1:0] sub_st;
  logic [3:0] bit_cnt;
  logic [2:0] byte_idx;
  logic [7:0] frame_mem [6];
  logic       scl_q;
  logic       sda_q;
  logic       drv_q;
  logic [7:0] dcmd_q;
  logic [7:0] addr_q;
  logic [7:0] disp_q;

  req_t pending_items [$];
  res_t expected_lines [$];

  int  n_issued;
  int  n_results;
  int  fail_count;
  int  frame_steps;
  int  frames_seen;
  int  ignored_pushes;
  int  acks_missed;
  int  settings_used;
  int  gap_left;
  int  stall_left;
  int  hold_left;
  int  ack_mode;
  bit  hold_req;
  bit  quiet;
  logic req_taken;

  always #5 clk = ~clk;

  // one bit slot of a byte; returns 1 once the eighth bit has been clocked
  function automatic bit shift_out(logic [7:0] b);
    bit last;
    last = 1'b0;
    case (sub_st)
      2'd0: begin
        bit_cnt = 4'd0;
        drv_q   = 1'b1;
        scl_q   = 1'b0;
        sub_st  = 2'd1;
      end
      2'd1: begin
        sda_q   = b[bit_cnt[2:0]];
        bit_cnt = bit_cnt + 4'd1;
        sub_st  = 2'd2;
      end
      2'd2: begin
        scl_q  = 1'b1;
        sub_st = 2'd3;
      end
      default: begin
        scl_q  = 1'b0;
        sub_st = 2'd1;
        if (bit_cnt >= BITS_PER_BYTE) begin
          sub_st = 2'd0;
          bus_st = BS_ACK;
          last   = 1'b1;
        end
      end
    endcase
    return last;
  endfunction

  function automatic res_t predict_line_step(req_t it);
    res_t r;
    r = '0;
    if (it.op == OP_PUSH) begin
      if (seq_ph == PH_IDLE) begin
        for (int i = 0; i < 6; i++) frame_mem[i] = it.bytes[i];
        seq_ph = PH_DCMD;
        r.accepted = 1'b1;
        frame_steps++;
      end else begin
        ignored_pushes++;
      end
    end else if (seq_ph != PH_IDLE) begin
      frame_steps++;
      case (bus_st)
        BS_START: begin
          if (seq_ph == PH_SEND) byte_idx = 3'd0;
          case (sub_st)
            2'd0: begin
              drv_q  = 1'b1;
              sda_q  = 1'b1;
              scl_q  = 1'b1;
              sub_st = 2'd1;
            end
            2'd1: begin
              sda_q  = 1'b0;
              sub_st = 2'd2;
            end
            2'd2: sub_st = 2'd3;
            default: begin
              scl_q  = 1'b0;
              sub_st = 2'd0;
              bus_st = (seq_ph == PH_SEND) ? BS_ADDR : BS_DATA;
            end
          endcase
        end
        BS_ADDR: begin
          if (seq_ph == PH_SEND) begin
            void'(shift_out(addr_q));
          end else begin
            bus_st = BS_START;
            sub_st = 2'd0;
            seq_ph = PH_IDLE;
          end
        end
        BS_ACK: begin
          case (sub_st)
            2'd0: begin
              drv_q  = 1'b0;
              sub_st = 2'd1;
            end
            2'd1: begin
              scl_q  = 1'b1;
              sub_st = 2'd2;
            end
            2'd2: begin
              r.ack_missing = it.sda_in;
              scl_q  = 1'b0;
              sub_st = 2'd0;
              bus_st = (seq_ph == PH_SEND) ? BS_DATA : BS_STOP;
            end
            default: sub_st = 2'd0;
          endcase
        end
        BS_DATA: begin
          if (seq_ph == PH_SEND) begin
            if (int'(byte_idx) >= FRAME_BYTES_DEF) begin
              byte_idx = 3'd0;
              bus_st   = BS_STOP;
            end else if (shift_out(frame_mem[byte_idx])) begin
              byte_idx = byte_idx + 3'd1;
            end
          end else begin
            void'(shift_out((seq_ph == PH_DCMD) ? dcmd_q : disp_q));
          end
        end
        BS_STOP: begin
          case (sub_st)
            2'd0: begin
              drv_q  = 1'b1;
              scl_q  = 1'b0;
              sda_q  = 1'b0;
              sub_st = 2'd1;
            end
            2'd1: begin
              scl_q  = 1'b1;
              sda_q  = 1'b1;
              sub_st = 2'd0;
              bus_st = BS_START;
              case (seq_ph)
                PH_DCMD: seq_ph = PH_SEND;
                PH_SEND: seq_ph = PH_DISP;
                default: begin
                  seq_ph = PH_IDLE;
                  r.frame_done = 1'b1;
                end
              endcase
            end
            default: sub_st = 2'd0;
          endcase
        end
        default: begin
          bus_st = BS_START;
          sub_st = 2'd0;
          seq_ph = PH_IDLE;
        end
      endcase
    end
    r.scl       = scl_q;
    r.sda_level = sda_q;
    r.sda_drive = drv_q;
    r.busy_res  = (seq_ph != PH_IDLE);
    return r;
  endfunction

  task automatic check_bit(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      fail_count++;
    end
  endtask

  // request driver
  always @(negedge clk) begin : drive_items
    req_t it;
    if (!rst && (!req_ch.valid || req_taken)) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        req_ch.valid <= 1'b0;
      end else if (!quiet && pending_items.size() > 0 && $urandom_range(0, 9) == 0) begin
        gap_left = $urandom_range(0, 2);
        req_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        n_issued++;
        req_ch.valid  <= 1'b1;
        req_ch.op     <= it.op;
        req_ch.sda_in <= it.sda_in;
        req_ch.byte0  <= it.bytes[0];
        req_ch.byte1  <= it.bytes[1];
        req_ch.byte2  <= it.bytes[2];
        req_ch.byte3  <= it.bytes[3];
        req_ch.byte4  <= it.bytes[4];
        req_ch.byte5  <= it.bytes[5];
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result ready: short random stalls, plus one long hold on request
  always @(negedge clk) begin : drive_ready
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD - 1;
      rsp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 2);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin : watch_items
    req_t it;
    res_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_ch.valid && req_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        it.op       = req_ch.op;
        it.sda_in   = req_ch.sda_in;
        it.bytes[0] = req_ch.byte0;
        it.bytes[1] = req_ch.byte1;
        it.bytes[2] = req_ch.byte2;
        it.bytes[3] = req_ch.byte3;
        it.bytes[4] = req_ch.byte4;
        it.bytes[5] = req_ch.byte5;
        expected_lines.push_back(predict_line_step(it));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        n_results <= n_results + 1;
        if (expected_lines.size() == 0) begin
          $error("result item with nothing outstanding");
          fail_count++;
        end else begin
          want = expected_lines.pop_front();
          check_bit("scl", want.scl, rsp_ch.scl);
          check_bit("sda_level", want.sda_level, rsp_ch.sda_level);
          check_bit("sda_drive", want.sda_drive, rsp_ch.sda_drive);
          check_bit("busy_res", want.busy_res, rsp_ch.busy_res);
          check_bit("accepted", want.accepted, rsp_ch.accepted);
          check_bit("frame_done", want.frame_done, rsp_ch.frame_done);
          check_bit("ack_missing", want.ack_missing, rsp_ch.ack_missing);
          if (rsp_ch.frame_done === 1'b1) frames_seen++;
          if (rsp_ch.ack_missing === 1'b1) acks_missed++;
        end
      end
    end
  end

  function automatic logic sda_pick();
    case (ack_mode)
      1: return 1'b0;
      2: return 1'b1;
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic req_t make_item(logic op, logic sda, logic [47:0] data);
    req_t it;
    it.op     = op;
    it.sda_in = sda;
    it.bytes  = data;
    return it;
  endfunction

  function automatic logic [47:0] rand_bytes();
    logic [47:0] d;
    d[47:32] = 16'($urandom);
    d[31:0]  = $urandom;
    return d;
  endfunction

  task automatic wait_drained();
    do @(posedge clk); while (pending_items.size() != 0 || n_results != n_issued);
  endtask

  task automatic finish_frame();
    wait_drained();
    while (seq_ph != PH_IDLE) begin
      repeat (8) pending_items.push_back(make_item(OP_TICK, sda_pick(), rand_bytes()));
      wait_drained();
    end
  endtask

  // write a register, then read it back
  task automatic cfg_access(logic [1:0] idx, logic [7:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {24'h0, val};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_DCMD: dcmd_q = val;
      REG_ADDR: addr_q = val;
      default:  disp_q = val;
    endcase
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {24'h0, val}) begin
      $error("prdata: expected %08h, got %08h", {24'h0, val}, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [7:0] cv [3];
    logic [47:0] fb;
    int p;
    int n_ticks;
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.op = OP_TICK;
    req_ch.sda_in = 1'b0;
    req_ch.byte0 = '0;
    req_ch.byte1 = '0;
    req_ch.byte2 = '0;
    req_ch.byte3 = '0;
    req_ch.byte4 = '0;
    req_ch.byte5 = '0;
    rsp_ch.ready = 1'b0;
    seq_ph = PH_IDLE;
    bus_st = BS_START;
    sub_st = '0;
    bit_cnt = '0;
    byte_idx = '0;
    for (int i = 0; i < 6; i++) frame_mem[i] = '0;
    scl_q = 1'b1;
    sda_q = 1'b1;
    drv_q = 1'b1;
    dcmd_q = DCMD_RST;
    addr_q = ADDR_RST;
    disp_q = DISP_RST;
    settings_used = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);

    // directed: idle ticks, push, pushes while busy, reset settings
    ack_mode = 1;
    pending_items.push_back(make_item(OP_TICK, 1'b0, 48'h0));
    pending_items.push_back(make_item(OP_TICK, 1'b1, {6{8'hFF}}));
    pending_items.push_back(make_item(OP_PUSH, 1'b0, 48'h0));
    pending_items.push_back(make_item(OP_PUSH, 1'b1, {6{8'hFF}}));
    for (int k = 0; k < 12; k++)
      pending_items.push_back(make_item(OP_TICK, 1'(k & 1), 48'h0));
    pending_items.push_back(make_item(OP_PUSH, 1'b0, {3{16'hA55A}}));
    pending_items.push_back(make_item(OP_PUSH, 1'b1, {3{16'h5AA5}}));
    finish_frame();

    p = 0;
    while (frame_steps < 950) begin
      quiet = (frame_steps >= 700);
      for (int r = 0; r < 3; r++) begin
        if (p == 0) cv[r] = 8'h00;
        else if (p == 1) cv[r] = 8'hFF;
        else cv[r] = 8'($urandom);
      end
      cfg_access(REG_DCMD, cv[0]);
      cfg_access(REG_ADDR, cv[1]);
      cfg_access(REG_DISP, cv[2]);
      settings_used++;
      ack_mode = p % 3;
      fb = (p == 0) ? {6{8'hFF}} : (p == 1) ? 48'h0 : rand_bytes();
      pending_items.push_back(make_item(OP_PUSH, sda_pick(), fb));
      if (p == 1) hold_req = 1'b1;
      n_ticks = $urandom_range(255, 285);
      for (int k = 0; k < n_ticks; k++) begin
        if (p == 2 && k == n_ticks / 2) wait_drained();
        if ($urandom_range(0, 15) == 0)
          pending_items.push_back(make_item(OP_PUSH, sda_pick(), rand_bytes()));
        pending_items.push_back(make_item(OP_TICK, sda_pick(), rand_bytes()));
      end
      finish_frame();
      p++;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Ran %0d frames over %0d register settings, %0d sequencer steps.",
             frames_seen, settings_used, frame_steps);
    $display("Pushes ignored while busy: %0d, missing acks reported: %0d.",
             ignored_pushes, acks_missed);
    if (fail_count == 0) begin
      $display("led_display_two_wire_frame_sender_tb OK");
    end else begin
      $display("led_display_two_wire_frame_sender_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("led_display_two_wire_frame_sender_tb NOT OK");
    $finish;
  end

endmodule
